// File: src/qsu_pkg.sv
// Package: shared types, codes and constants of the quoted string unescaper.
`timescale 1ns / 1ps
`default_nettype none

package qsu_pkg;

  localparam int COUNT_BITS_DEFAULT = 16;
  localparam int CAP_W = 16;
  localparam int LEN_W = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 16'd256;
  localparam int MAX_RES = 4;

  // Character codes
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_N  = 8'h6e;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_UP_U   = 8'h55;
  localparam logic [7:0] CH_DEL    = 8'h7f;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_CR     = 8'h0d;

  // Code point limits and UTF-8 marks
  localparam logic [31:0] CP_MAX     = 32'h0010ffff;
  localparam logic [31:0] CP_SUR_LO  = 32'h0000d800;
  localparam logic [31:0] CP_SUR_HI  = 32'h0000dfff;
  localparam logic [31:0] CP_1B_MAX  = 32'h0000007f;
  localparam logic [31:0] CP_2B_MAX  = 32'h000007ff;
  localparam logic [31:0] CP_3B_MAX  = 32'h0000ffff;
  localparam logic [7:0]  UTF_LEAD2  = 8'hc0;
  localparam logic [7:0]  UTF_LEAD3  = 8'he0;
  localparam logic [7:0]  UTF_LEAD4  = 8'hf0;
  localparam logic [7:0]  UTF_CONT   = 8'h80;

  localparam logic [3:0] HEX_SHORT = 4'd4;
  localparam logic [3:0] HEX_LONG  = 4'd8;

  typedef enum logic [2:0] {
    PH_AWAIT = 3'd0,
    PH_BODY  = 3'd1,
    PH_ESC   = 3'd2,
    PH_HEX   = 3'd3,
    PH_STOP  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    kind_t            kind;
    logic [LEN_W-1:0] length;
  } result_t;

  typedef struct packed {
    logic [2:0]                count;
    result_t [MAX_RES-1:0]     item;
  } res_bundle_t;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  hex_left;
    logic [31:0] code_accum;
  } core_state_t;

endpackage

`default_nettype wire

// File: src/qsu_in_if.sv
// Interface: raw byte channel into the unescaper.
`timescale 1ns / 1ps
`default_nettype none

interface qsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;

  modport source (output valid, output data_byte, output first, input ready);
  modport sink (input valid, input data_byte, input first, output ready);
endinterface

`default_nettype wire

// File: src/qsu_out_if.sv
// Interface: decoded result channel out of the unescaper.
`timescale 1ns / 1ps
`default_nettype none

interface qsu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [1:0]  kind;
  logic        last;
  logic [15:0] length;

  modport source (output valid, output out_byte, output kind, output last,
                  output length, input ready);
  modport sink (input valid, input out_byte, input kind, input last,
                input length, output ready);
endinterface

`default_nettype wire

// File: src/quoted_string_unescaper_core.sv
// Top level: quoted string unescaper with input register, parse state and result register.
//
//  channel      dir   handshake     payload
//  raw_bytes    in    valid/ready   data_byte[7:0], first
//  results      out   valid/ready   out_byte[7:0], kind[1:0], last, length[15:0]
//  cfg          in    cfg_wr_en     cfg_wr_data[15:0] -> out_capacity
//
//  A byte is taken into the input register, decoded combinationally into 0 to 4 results
//  and loaded into the result register, which hands out one result per cycle while ready.
//  Bytes giving at most one result flow at one per cycle while the result side is ready;
//  a code point of n UTF-8 bytes gives n results and stalls the input until the last
//  of them leaves. Reset (rst, synchronous) empties both registers, sets capacity to 256
//  and awaits an opening quote. A stalled result side holds one further byte only.
`timescale 1ns / 1ps
`default_nettype none

module quoted_string_unescaper_core #(
  parameter int COUNT_BITS = qsu_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  qsu_in_if.sink                          raw_bytes,
  qsu_out_if.source                       results,
  input  wire logic                       cfg_wr_en,
  input  wire logic [qsu_pkg::CAP_W-1:0]  cfg_wr_data
);

  logic                        hold_valid;
  logic [7:0]                  hold_byte;
  logic                        hold_first;
  logic                        accept;
  logic                        advance;
  logic                        q_free;
  logic                        load;

  qsu_pkg::core_state_t        state;
  qsu_pkg::core_state_t        state_next;
  logic [COUNT_BITS-1:0]       written_count;
  logic [COUNT_BITS-1:0]       written_count_next;
  logic [qsu_pkg::CAP_W-1:0]   out_capacity;
  qsu_pkg::res_bundle_t        res;

  assign advance         = hold_valid && q_free;
  assign raw_bytes.ready = !hold_valid || advance;
  assign accept          = raw_bytes.valid && raw_bytes.ready;
  assign load            = advance && (res.count != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_byte  <= raw_bytes.data_byte;
      hold_first <= raw_bytes.first;
    end
  end

  // Advance parse state only when the held byte moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase      <= qsu_pkg::PH_AWAIT;
      state.hex_left   <= 4'd0;
      state.code_accum <= 32'd0;
      written_count    <= '0;
    end else if (advance) begin
      state         <= state_next;
      written_count <= written_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= qsu_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      out_capacity <= cfg_wr_data;
    end
  end

  qsu_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .data_byte          (hold_byte),
    .first              (hold_first),
    .cur                (state),
    .written_count      (written_count),
    .out_capacity       (out_capacity),
    .nxt                (state_next),
    .written_count_next (written_count_next),
    .res                (res)
  );

  qsu_result_q u_result_q (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .res     (res),
    .free    (q_free),
    .results (results)
  );

`ifndef ASSERT_OFF
  a_first_clears_count: assert property (@(posedge clk) disable iff (rst)
    (advance && hold_first) |=> (written_count == '0))
    else $error("length not cleared on a new string");
  a_hex_pending: assert property (@(posedge clk) disable iff (rst)
    (state.phase == qsu_pkg::PH_HEX) |-> (state.hex_left != 4'd0))
    else $error("hex phase with no digits left");
  a_hold_kept: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && !q_free) |=> (hold_valid && $stable(hold_byte)))
    else $error("held byte lost while result register busy");
`endif

endmodule

`default_nettype wire

// File: src/qsu_step.sv
// Combinational decode of one held byte: next parse state and up to four results.
`timescale 1ns / 1ps
`default_nettype none

module qsu_step #(
  parameter int COUNT_BITS = qsu_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic [7:0]                  data_byte,
  input  wire logic                        first,
  input  wire qsu_pkg::core_state_t        cur,
  input  wire logic [COUNT_BITS-1:0]       written_count,
  input  wire logic [qsu_pkg::CAP_W-1:0]   out_capacity,
  output qsu_pkg::core_state_t             nxt,
  output logic [COUNT_BITS-1:0]            written_count_next,
  output qsu_pkg::res_bundle_t             res
);

  localparam int SUM_W = ((COUNT_BITS > qsu_pkg::CAP_W) ? COUNT_BITS : qsu_pkg::CAP_W) + 1;

  logic [SUM_W-1:0]  cap_lim;
  logic [SUM_W-1:0]  cap_ext;
  logic [SUM_W-1:0]  usable;
  logic [SUM_W-1:0]  wc_ext;
  logic [3:0]        digit;
  logic              digit_ok;
  logic [31:0]       accum_shift;
  logic [3:0]        hex_dec;
  logic [7:0]        simple_cp;
  logic              simple_ok;
  logic [31:0]       cp_sel;
  logic              cp_ok;
  logic [2:0]        enc_n;
  logic [7:0]        enc [qsu_pkg::MAX_RES];
  logic              room;

  // Hex digit value
  always_comb begin
    digit    = 4'd0;
    digit_ok = 1'b1;
    if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
      digit = data_byte[3:0];
    end else if ((data_byte >= 8'h61 && data_byte <= 8'h66) ||
                 (data_byte >= 8'h41 && data_byte <= 8'h46)) begin
      digit = data_byte[3:0] + 4'd9;
    end else begin
      digit_ok = 1'b0;
    end
  end

  assign accum_shift = {cur.code_accum[27:0], digit};
  assign hex_dec     = cur.hex_left - 4'd1;

  // Single-letter escapes
  always_comb begin
    simple_ok = 1'b1;
    unique case (data_byte)
      qsu_pkg::CH_QUOTE:  simple_cp = qsu_pkg::CH_QUOTE;
      qsu_pkg::CH_BSLASH: simple_cp = qsu_pkg::CH_BSLASH;
      qsu_pkg::CH_LOW_B:  simple_cp = qsu_pkg::CH_BS;
      qsu_pkg::CH_LOW_T:  simple_cp = qsu_pkg::CH_TAB;
      qsu_pkg::CH_LOW_N:  simple_cp = qsu_pkg::CH_LF;
      qsu_pkg::CH_LOW_F:  simple_cp = qsu_pkg::CH_FF;
      qsu_pkg::CH_LOW_R:  simple_cp = qsu_pkg::CH_CR;
      default: begin
        simple_cp = 8'd0;
        simple_ok = 1'b0;
      end
    endcase
  end

  assign cp_sel = (cur.phase == qsu_pkg::PH_ESC) ? {24'd0, simple_cp} : accum_shift;
  assign cp_ok  = (cp_sel != 32'd0) && (cp_sel <= qsu_pkg::CP_MAX) &&
                  !((cp_sel >= qsu_pkg::CP_SUR_LO) && (cp_sel <= qsu_pkg::CP_SUR_HI));

  // UTF-8 encoder
  always_comb begin
    enc[0] = cp_sel[7:0];
    enc[1] = 8'd0;
    enc[2] = 8'd0;
    enc[3] = 8'd0;
    enc_n  = 3'd1;
    if (cp_sel <= qsu_pkg::CP_1B_MAX) begin
      enc_n = 3'd1;
    end else if (cp_sel <= qsu_pkg::CP_2B_MAX) begin
      enc[0] = qsu_pkg::UTF_LEAD2 | {3'd0, cp_sel[10:6]};
      enc[1] = qsu_pkg::UTF_CONT | {2'd0, cp_sel[5:0]};
      enc_n  = 3'd2;
    end else if (cp_sel <= qsu_pkg::CP_3B_MAX) begin
      enc[0] = qsu_pkg::UTF_LEAD3 | {4'd0, cp_sel[15:12]};
      enc[1] = qsu_pkg::UTF_CONT | {2'd0, cp_sel[11:6]};
      enc[2] = qsu_pkg::UTF_CONT | {2'd0, cp_sel[5:0]};
      enc_n  = 3'd3;
    end else begin
      enc[0] = qsu_pkg::UTF_LEAD4 | {5'd0, cp_sel[20:18]};
      enc[1] = qsu_pkg::UTF_CONT | {2'd0, cp_sel[17:12]};
      enc[2] = qsu_pkg::UTF_CONT | {2'd0, cp_sel[11:6]};
      enc[3] = qsu_pkg::UTF_CONT | {2'd0, cp_sel[5:0]};
      enc_n  = 3'd4;
    end
  end

  // Usable capacity is capped by the counter range
  assign cap_lim = SUM_W'(1) << COUNT_BITS;
  assign cap_ext = SUM_W'(out_capacity);
  assign usable  = (cap_ext > cap_lim) ? cap_lim : cap_ext;
  assign wc_ext  = SUM_W'(written_count);
  assign room    = (wc_ext + SUM_W'(enc_n)) < usable;

  always_comb begin
    nxt                = cur;
    written_count_next = written_count;
    res.count          = 3'd0;
    for (int i = 0; i < qsu_pkg::MAX_RES; i++) begin
      res.item[i].out_byte = 8'd0;
      res.item[i].kind     = qsu_pkg::KIND_ERR;
      res.item[i].length   = '0;
    end

    if (first) begin
      nxt.hex_left       = 4'd0;
      nxt.code_accum     = 32'd0;
      written_count_next = '0;
      if (data_byte == qsu_pkg::CH_QUOTE) begin
        nxt.phase = qsu_pkg::PH_BODY;
      end else begin
        nxt.phase = qsu_pkg::PH_STOP;
        res.count = 3'd1;
      end
    end else begin
      unique case (cur.phase)
        qsu_pkg::PH_BODY: begin
          if (data_byte == qsu_pkg::CH_QUOTE) begin
            nxt.phase = qsu_pkg::PH_STOP;
            res.count = 3'd1;
            if (wc_ext < usable) begin
              res.item[0].kind   = qsu_pkg::KIND_DONE;
              res.item[0].length = qsu_pkg::LEN_W'(written_count);
            end
          end else if (data_byte == qsu_pkg::CH_BSLASH) begin
            nxt.phase = qsu_pkg::PH_ESC;
          end else if (data_byte < qsu_pkg::CH_SPACE || data_byte == qsu_pkg::CH_DEL ||
                       (wc_ext + SUM_W'(1)) >= usable) begin
            nxt.phase = qsu_pkg::PH_STOP;
            res.count = 3'd1;
          end else begin
            res.count            = 3'd1;
            res.item[0].out_byte = data_byte;
            res.item[0].kind     = qsu_pkg::KIND_BYTE;
            written_count_next   = written_count + COUNT_BITS'(1);
          end
        end
        qsu_pkg::PH_ESC: begin
          nxt.phase = qsu_pkg::PH_BODY;
          if (data_byte == qsu_pkg::CH_LOW_U || data_byte == qsu_pkg::CH_UP_U) begin
            nxt.phase      = qsu_pkg::PH_HEX;
            nxt.code_accum = 32'd0;
            nxt.hex_left   = (data_byte == qsu_pkg::CH_LOW_U) ? qsu_pkg::HEX_SHORT
                                                               : qsu_pkg::HEX_LONG;
          end else if (simple_ok && room) begin
            res.count = enc_n;
            for (int i = 0; i < qsu_pkg::MAX_RES; i++) begin
              res.item[i].out_byte = enc[i];
              res.item[i].kind     = qsu_pkg::KIND_BYTE;
            end
            written_count_next = written_count + COUNT_BITS'(enc_n);
          end else begin
            nxt.phase = qsu_pkg::PH_STOP;
            res.count = 3'd1;
          end
        end
        qsu_pkg::PH_HEX: begin
          if (!digit_ok) begin
            nxt.phase = qsu_pkg::PH_STOP;
            res.count = 3'd1;
          end else begin
            nxt.code_accum = accum_shift;
            nxt.hex_left   = hex_dec;
            if (hex_dec == 4'd0) begin
              if (cp_ok && room) begin
                nxt.phase = qsu_pkg::PH_BODY;
                res.count = enc_n;
                for (int i = 0; i < qsu_pkg::MAX_RES; i++) begin
                  res.item[i].out_byte = enc[i];
                  res.item[i].kind     = qsu_pkg::KIND_BYTE;
                end
                written_count_next = written_count + COUNT_BITS'(enc_n);
              end else begin
                nxt.phase = qsu_pkg::PH_STOP;
                res.count = 3'd1;
              end
            end
          end
        end
        default: begin
          // awaiting quote or stopped: drop the byte
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/qsu_result_q.sv
// Result register: holds up to four results of one byte and hands them out in order.
`timescale 1ns / 1ps
`default_nettype none

module qsu_result_q (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire qsu_pkg::res_bundle_t res,
  output logic                      free,
  qsu_out_if.source                 results
);

  qsu_pkg::result_t [qsu_pkg::MAX_RES-1:0] entries;
  logic [2:0]                              rem;
  logic                                    take;

  assign take = (rem != 3'd0) && results.ready;
  // Free when empty, or when the final entry leaves this cycle
  assign free = (rem == 3'd0) || ((rem == 3'd1) && take);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 3'd0;
    end else if (load) begin
      rem <= res.count;
    end else if (take) begin
      rem <= rem - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entries <= res.item;
    end else if (take) begin
      entries[qsu_pkg::MAX_RES-2:0] <= entries[qsu_pkg::MAX_RES-1:1];
    end
  end

  assign results.valid    = (rem != 3'd0);
  assign results.out_byte = entries[0].out_byte;
  assign results.kind     = 2'(entries[0].kind);
  assign results.last     = (rem == 3'd1);
  assign results.length   = entries[0].length;

`ifndef ASSERT_OFF
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("result register loaded while results still pending");
  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    ((rem != 3'd0) && (entries[0].kind != qsu_pkg::KIND_BYTE)) |-> (rem == 3'd1))
    else $error("completion or error result not last of its byte");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    rem <= 3'(qsu_pkg::MAX_RES))
    else $error("pending result count out of range");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Testbench for the quoted string unescaper: own decoder, random strings, result checks.
`timescale 1ns / 1ps

module tb_top;
  import qsu_pkg::*;

  localparam int COUNT_BITS = COUNT_BITS_DEFAULT;
  localparam int CLK_HALF = 6;
  localparam int SETTLE_CYCLES = 6;
  localparam int END_CYCLES = 20;

  typedef struct {
    logic [7:0]       out_byte;
    kind_t            kind;
    logic             last;
    logic [LEN_W-1:0] length;
  } decoded_t;

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data;

  qsu_in_if  raw_if ();
  qsu_out_if res_if ();

  quoted_string_unescaper_core dut (
    .clk         (clk),
    .rst         (rst),
    .raw_bytes   (raw_if),
    .results     (res_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Decoder state kept alongside the block
  phase_t           pr_phase;
  logic [3:0]       pr_hex_left;
  logic [31:0]      pr_accum;
  int unsigned      pr_count;
  logic [CAP_W-1:0] pr_capacity;

  decoded_t step_out[$];
  decoded_t decoded_q[$];

  int mismatch_count;
  int parsed_bytes;
  int idle_pct;
  int stall_pct;

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  always @(posedge clk) begin
    res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------- decoder

  function automatic int hex_val(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic longint unsigned usable_room();
    longint unsigned lim;
    lim = longint'(1) << COUNT_BITS;
    return (pr_capacity < lim) ? pr_capacity : lim;
  endfunction

  function automatic void add_out(logic [7:0] b, kind_t k, logic [LEN_W-1:0] len);
    decoded_t r;
    r.out_byte = b;
    r.kind = k;
    r.last = 1'b0;
    r.length = len;
    step_out.push_back(r);
  endfunction

  function automatic void reject();
    add_out(8'h00, KIND_ERR, '0);
    pr_phase = PH_STOP;
  endfunction

  // Encode one code point as UTF-8; zero means the code point is refused
  function automatic bit place_code(logic [31:0] cp);
    logic [7:0] enc [4];
    int n;
    if (cp == 0 || cp > CP_MAX || (cp >= CP_SUR_LO && cp <= CP_SUR_HI)) return 1'b0;
    if (cp <= CP_1B_MAX) begin
      enc[0] = cp[7:0];
      n = 1;
    end else if (cp <= CP_2B_MAX) begin
      enc[0] = UTF_LEAD2 | {3'd0, cp[10:6]};
      enc[1] = UTF_CONT | {2'd0, cp[5:0]};
      n = 2;
    end else if (cp <= CP_3B_MAX) begin
      enc[0] = UTF_LEAD3 | {4'd0, cp[15:12]};
      enc[1] = UTF_CONT | {2'd0, cp[11:6]};
      enc[2] = UTF_CONT | {2'd0, cp[5:0]};
      n = 3;
    end else begin
      enc[0] = UTF_LEAD4 | {5'd0, cp[20:18]};
      enc[1] = UTF_CONT | {2'd0, cp[17:12]};
      enc[2] = UTF_CONT | {2'd0, cp[11:6]};
      enc[3] = UTF_CONT | {2'd0, cp[5:0]};
      n = 4;
    end
    if (longint'(pr_count) + n >= usable_room()) return 1'b0;
    for (int i = 0; i < n; i++) add_out(enc[i], KIND_BYTE, '0);
    pr_count += n;
    return 1'b1;
  endfunction

  function automatic void unescape_byte(logic [7:0] b, logic f);
    logic [31:0] cp;
    int d;
    step_out.delete();
    if (f) begin
      pr_hex_left = '0;
      pr_accum = '0;
      pr_count = 0;
      if (b == CH_QUOTE) pr_phase = PH_BODY;
      else reject();
    end else begin
      case (pr_phase)
        PH_BODY: begin
          if (b == CH_QUOTE) begin
            if (pr_count < usable_room()) begin
              add_out(8'h00, KIND_DONE, LEN_W'(pr_count));
              pr_phase = PH_STOP;
            end else begin
              reject();
            end
          end else if (b == CH_BSLASH) begin
            pr_phase = PH_ESC;
          end else if (b < CH_SPACE || b == CH_DEL ||
                       longint'(pr_count) + 1 >= usable_room()) begin
            reject();
          end else begin
            add_out(b, KIND_BYTE, '0);
            pr_count++;
          end
        end
        PH_ESC: begin
          cp = '0;
          pr_phase = PH_BODY;
          case (b)
            CH_QUOTE:  cp = {24'd0, CH_QUOTE};
            CH_BSLASH: cp = {24'd0, CH_BSLASH};
            CH_LOW_B:  cp = {24'd0, CH_BS};
            CH_LOW_T:  cp = {24'd0, CH_TAB};
            CH_LOW_N:  cp = {24'd0, CH_LF};
            CH_LOW_F:  cp = {24'd0, CH_FF};
            CH_LOW_R:  cp = {24'd0, CH_CR};
            CH_LOW_U: begin
              pr_phase = PH_HEX;
              pr_hex_left = HEX_SHORT;
              pr_accum = '0;
            end
            CH_UP_U: begin
              pr_phase = PH_HEX;
              pr_hex_left = HEX_LONG;
              pr_accum = '0;
            end
            default: reject();
          endcase
          if (cp != 0 && !place_code(cp)) reject();
        end
        PH_HEX: begin
          d = hex_val(b);
          if (d < 0) begin
            reject();
          end else begin
            pr_accum = {pr_accum[27:0], 4'(d)};
            pr_hex_left = pr_hex_left - 4'd1;
            if (pr_hex_left == 0) begin
              pr_phase = PH_BODY;
              if (!place_code(pr_accum)) reject();
            end
          end
        end
        default: ;
      endcase
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    foreach (step_out[i]) decoded_q.push_back(step_out[i]);
  endfunction

  // ---------------------------------------------------------------- checker

  task automatic report_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin : check_results
    decoded_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (decoded_q.size() == 0) begin
        report_failure($sformatf("unexpected result: byte %02h kind %0d last %0b length %0d",
                                 res_if.out_byte, res_if.kind, res_if.last, res_if.length));
      end else begin
        want = decoded_q.pop_front();
        if (res_if.out_byte !== want.out_byte || res_if.kind !== want.kind ||
            res_if.last !== want.last || res_if.length !== want.length) begin
          report_failure($sformatf(
            "mismatch: expected byte %02h kind %0d last %0b length %0d, got %02h %0d %0b %0d",
            want.out_byte, want.kind, want.last, want.length,
            res_if.out_byte, res_if.kind, res_if.last, res_if.length));
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_byte(input logic [7:0] b, input logic f);
    if (f || (pr_phase != PH_AWAIT && pr_phase != PH_STOP)) parsed_bytes++;
    while ($urandom_range(99) < idle_pct) begin
      raw_if.valid <= 1'b0;
      @(posedge clk);
    end
    raw_if.valid <= 1'b1;
    raw_if.data_byte <= b;
    raw_if.first <= f;
    do @(posedge clk); while (!raw_if.ready);
    unescape_byte(b, f);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic open_string();
    send_byte(CH_QUOTE, 1'b1);
  endtask

  // Hold the request line low until every decoded result has come out
  task automatic hold_until_drained();
    raw_if.valid <= 1'b0;
    do @(posedge clk); while (decoded_q.size() != 0);
  endtask

  task automatic wait_idle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] value);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pr_capacity = value;
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    logic upper;
    upper = 1'($urandom_range(1));
    if (nib < 10) return "0" + {4'd0, nib};
    return (upper ? "A" : "a") + {4'd0, nib} - 8'd10;
  endfunction

  task automatic send_hex_escape(input logic [31:0] cp, input logic wide);
    int digits;
    digits = wide ? 8 : 4;
    send_byte(CH_BSLASH, 1'b0);
    send_byte(wide ? CH_UP_U : CH_LOW_U, 1'b0);
    for (int i = digits - 1; i >= 0; i--) send_byte(hex_char(cp[4*i +: 4]), 1'b0);
  endtask

  // Valid code point, spread over the UTF-8 length classes (four-byte ones only when wide), edges now and then
  function automatic logic [31:0] pick_code_point(logic wide);
    logic [31:0] lo, hi, cp;
    case ($urandom_range(wide ? 3 : 2))
      0: begin lo = 32'd1;         hi = CP_1B_MAX; end
      1: begin lo = CP_1B_MAX + 1; hi = CP_2B_MAX; end
      2: begin lo = CP_2B_MAX + 1; hi = CP_3B_MAX; end
      default: begin lo = CP_3B_MAX + 1; hi = CP_MAX; end
    endcase
    if ($urandom_range(3) == 0) cp = $urandom_range(1) ? hi : lo;
    else cp = $urandom_range(hi, lo);
    if (cp >= CP_SUR_LO && cp <= CP_SUR_HI) cp = cp ^ 32'h0000_4000;
    return cp;
  endfunction

  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(255, CH_SPACE));
    while (c == CH_QUOTE || c == CH_BSLASH || c == CH_DEL);
    return c;
  endfunction

  task automatic send_good_segment();
    logic [7:0] c;
    case ($urandom_range(5))
      0, 1, 2: send_byte(pick_plain(), 1'b0);
      3: begin
        case ($urandom_range(6))
          0: c = CH_QUOTE;
          1: c = CH_BSLASH;
          2: c = CH_LOW_B;
          3: c = CH_LOW_T;
          4: c = CH_LOW_N;
          5: c = CH_LOW_F;
          default: c = CH_LOW_R;
        endcase
        send_byte(CH_BSLASH, 1'b0);
        send_byte(c, 1'b0);
      end
      4: send_hex_escape(pick_code_point(1'b0), 1'b0);
      default: send_hex_escape(pick_code_point(1'b1), 1'b1);
    endcase
  endtask

  task automatic send_bad_segment();
    logic [7:0] c;
    logic [31:0] cp;
    case ($urandom_range(6))
      0: send_byte(8'($urandom_range(CH_SPACE - 1, 0)), 1'b0);
      1: send_byte(CH_DEL, 1'b0);
      2: begin
        do c = 8'($urandom_range(255));
        while (c == CH_QUOTE || c == CH_BSLASH || c == CH_LOW_B || c == CH_LOW_T ||
               c == CH_LOW_N || c == CH_LOW_F || c == CH_LOW_R || c == CH_LOW_U ||
               c == CH_UP_U);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(c, 1'b0);
      end
      3: begin
        send_byte(CH_BSLASH, 1'b0);
        send_byte($urandom_range(1) ? CH_UP_U : CH_LOW_U, 1'b0);
        repeat ($urandom_range(3)) send_byte(hex_char(4'($urandom_range(15))), 1'b0);
        do c = 8'($urandom_range(255)); while (hex_val(c) >= 0);
        send_byte(c, 1'b0);
      end
      4: begin
        case ($urandom_range(2))
          0: cp = '0;
          1: cp = $urandom_range(CP_SUR_HI, CP_SUR_LO);
          default: cp = $urandom_range(1) ? CP_SUR_HI : CP_SUR_LO;
        endcase
        send_hex_escape(cp, 1'($urandom_range(1)));
      end
      5: begin
        cp = $urandom_range(1) ? CP_MAX + 1 + $urandom_range(255) : ($urandom | 32'h0020_0000);
        send_hex_escape(cp, 1'b1);
      end
      default: begin
        // abandon the string and restart with a fresh one
        open_string();
        send_good_segment();
        send_byte(CH_QUOTE, 1'b0);
      end
    endcase
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_plain_and_escapes();
    send_byte("x", 1'b0);
    open_string();
    send_byte(CH_SPACE, 1'b0);
    send_byte(8'hff, 1'b0);
    send_text("\\\"\\\\\\b\\t\\n\\f\\r");
    send_text("\\u0001\\u07FF\\U0010ffff");
    send_byte(CH_QUOTE, 1'b0);
    send_byte("z", 1'b0);
  endtask

  task automatic test_rejections();
    send_byte("a", 1'b1);
    open_string();
    send_text("ok");
    send_byte(8'h1f, 1'b0);
    open_string();
    send_byte(CH_DEL, 1'b0);
    open_string();
    send_byte(8'h00, 1'b0);
    open_string();
    send_text("\\x");
    open_string();
    send_text("\\u12g");
    open_string();
    send_text("\\u0000");
    open_string();
    send_text("\\uD800");
    open_string();
    send_text("\\U00110000");
    hold_until_drained();
    open_string();
    send_text("ab");
    open_string();
    send_text("c\"");
  endtask

  task automatic test_capacity_edges();
    set_capacity(16'd0);
    open_string();
    send_byte(CH_QUOTE, 1'b0);
    open_string();
    send_text("a");
    set_capacity(16'd1);
    open_string();
    send_byte(CH_QUOTE, 1'b0);
    open_string();
    send_text("a");
    set_capacity(16'd2);
    open_string();
    send_text("a\\n");
    set_capacity(16'd3);
    open_string();
    send_text("\\u00e9\"");
    open_string();
    send_text("\\u0800");
    set_capacity(16'd5);
    open_string();
    send_text("\\U0001F600\"");
    set_capacity(16'hffff);
    open_string();
    send_text("hi\"");
  endtask

  task automatic test_random_traffic(input int idle, input int stall,
                                     input logic [CAP_W-1:0] capacity, input int quota);
    int target;
    int mode;
    set_capacity(capacity);
    idle_pct = idle;
    stall_pct = stall;
    target = parsed_bytes + quota;
    while (parsed_bytes < target) begin
      mode = $urandom_range(99);
      if (mode >= 88) begin
        // noise: raw bytes, the odd one flagged as a string start
        repeat ($urandom_range(6, 1)) begin
          send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
        end
      end else begin
        open_string();
        repeat ($urandom_range(10)) send_good_segment();
        if (mode < 72) send_byte(CH_QUOTE, 1'b0);
        else send_bad_segment();
        if ($urandom_range(7) == 0) send_byte(pick_plain(), 1'b0);
      end
      if ($urandom_range(15) == 0) hold_until_drained();
    end
  endtask

  initial begin : run
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    raw_if.valid = 1'b0;
    raw_if.data_byte = '0;
    raw_if.first = 1'b0;
    res_if.ready = 1'b0;
    pr_capacity = CAP_RESET;
    pr_phase = PH_AWAIT;
    pr_hex_left = '0;
    pr_accum = '0;
    pr_count = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_plain_and_escapes();
    test_rejections();
    test_capacity_edges();
    test_random_traffic(0, 0, CAP_RESET, 40);
    test_random_traffic(83, 0, CAP_W'($urandom_range(24, 2)), 40);
    test_random_traffic(0, 83, 16'hffff, 40);
    test_random_traffic(26, 26, CAP_W'($urandom_range(40, 1)), 40);

    hold_until_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("FAIL");
    $finish;
  end

endmodule
